/* rtl/core/laes_pkg.sv */
`timescale 1ns / 1ps

package laes_pkg;

  // The APB decode covers eight 32-bit registers.
  localparam int ADDR_W = 5;

  // Microprogram length for one Euler step, including output scaling.
  localparam int NUM_STEPS = 12;

  typedef struct packed {
    logic [30:0]        sigma;
    logic [30:0]        rho;
    logic [30:0]        beta;
    logic [23:0]        time_step;
    logic [30:0]        zoom;
    logic signed [31:0] z_offset;
    logic signed [31:0] start_x;
    logic [19:0]        run_length;
  } cfg_t;

  typedef enum logic [3:0] {
    SRC_X, SRC_Y, SRC_Z, SRC_NX, SRC_NY, SRC_NZ,
    SRC_T0, SRC_T1, SRC_T2, SRC_T3,
    SRC_SIGMA, SRC_RHO, SRC_BETA, SRC_DT, SRC_ZOOM, SRC_ZOFF
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_T0, DST_T1, DST_T2, DST_T3,
    DST_NX, DST_NY, DST_NZ, DST_RX, DST_RY, DST_RZ
  } dst_t;

  typedef struct packed {
    logic start;
    logic commit;
    logic out_load;
    src_t alu_a;
    src_t alu_b;
    logic alu_sub;
    dst_t alu_dst;
    logic mul_en;
    src_t mul_a;
    src_t mul_b;
    logic mul_dt;
    dst_t rnd_dst;
  } cmd_t;

  // Reset value of start_x: 0.1 in the chosen fixed-point format, rounded.
  function automatic logic signed [31:0] start_x_reset(int frac_bits);
    int unsigned one_q;
    one_q = 32'd1 << frac_bits;
    return 32'((one_q + 32'd5) / 32'd10);
  endfunction

endpackage

/* rtl/core/lorenz_attractor_euler_step_core.sv */
`timescale 1ns / 1ps
// A result is loaded into the point outputs in the handover state after the last step.
// A new transaction is accepted only when idle, or in the handover state once the output
// is free; the single shared 32x32 multiplier carries all ten products of a step
// through a 12-step microprogram, and a step does not overlap the next one.
// Reset (synchronous, active high) loads the default coefficients and the start point.

module lorenz_attractor_euler_step_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [laes_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        step_valid,
  output logic                        step_stall,
  input  logic                        restart,
  output logic                        point_valid,
  input  logic                        point_stall,
  output logic signed [31:0]          point_x,
  output logic signed [31:0]          point_y,
  output logic signed [31:0]          point_z,
  output logic                        last_of_run
);
  import laes_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  laes_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  laes_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step_valid  (step_valid),
    .step_stall  (step_stall),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .cmd         (cmd)
  );

  laes_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .restart     (restart),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .last_of_run (last_of_run)
  );

endmodule

/* rtl/core/laes_cfg.sv */
`timescale 1ns / 1ps

module laes_cfg #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [laes_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output laes_pkg::cfg_t              cfg
);
  import laes_pkg::*;

  typedef enum logic [2:0] {
    REG_SIGMA, REG_RHO, REG_BETA, REG_TIME_STEP,
    REG_ZOOM, REG_Z_OFFSET, REG_START_X, REG_RUN_LENGTH
  } reg_idx_t;

  localparam int unsigned ONE_Q = 32'd1 << FRAC_BITS;
  localparam logic [30:0] SIGMA_RST = 31'(10 * ONE_Q);
  localparam logic [30:0] RHO_RST   = 31'(28 * ONE_Q);
  localparam logic [30:0] BETA_RST  = 31'((8 * ONE_Q + 1) / 3);
  localparam logic [23:0] DT_RST    = 24'd167772;
  localparam logic [30:0] ZOOM_RST  = 31'(4 * ONE_Q);
  localparam logic [31:0] ZOFF_RST  = 32'(15 * ONE_Q);
  localparam logic [19:0] RUN_RST   = 20'd20000;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sigma      <= SIGMA_RST;
      cfg.rho        <= RHO_RST;
      cfg.beta       <= BETA_RST;
      cfg.time_step  <= DT_RST;
      cfg.zoom       <= ZOOM_RST;
      cfg.z_offset   <= ZOFF_RST;
      cfg.start_x    <= start_x_reset(FRAC_BITS);
      cfg.run_length <= RUN_RST;
    end else if (wr) begin
      unique case (idx)
        REG_SIGMA:      cfg.sigma      <= pwdata[30:0];
        REG_RHO:        cfg.rho        <= pwdata[30:0];
        REG_BETA:       cfg.beta       <= pwdata[30:0];
        REG_TIME_STEP:  cfg.time_step  <= pwdata[23:0];
        REG_ZOOM:       cfg.zoom       <= pwdata[30:0];
        REG_Z_OFFSET:   cfg.z_offset   <= pwdata;
        REG_START_X:    cfg.start_x    <= pwdata;
        REG_RUN_LENGTH: cfg.run_length <= pwdata[19:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SIGMA:      prdata = {1'b0, cfg.sigma};
      REG_RHO:        prdata = {1'b0, cfg.rho};
      REG_BETA:       prdata = {1'b0, cfg.beta};
      REG_TIME_STEP:  prdata = {8'd0, cfg.time_step};
      REG_ZOOM:       prdata = {1'b0, cfg.zoom};
      REG_Z_OFFSET:   prdata = cfg.z_offset;
      REG_START_X:    prdata = cfg.start_x;
      REG_RUN_LENGTH: prdata = {12'd0, cfg.run_length};
    endcase
  end

endmodule

/* rtl/core/laes_ctrl.sv */
`timescale 1ns / 1ps

module laes_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           step_valid,
  output logic           step_stall,
  output logic           point_valid,
  input  logic           point_stall,
  output laes_pkg::cmd_t cmd
);
  import laes_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HAND} state_t;

  localparam int STEP_W = $clog2(NUM_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  localparam cmd_t CMD_IDLE = '{
    start:    1'b0,
    commit:   1'b0,
    out_load: 1'b0,
    alu_a:    SRC_X,
    alu_b:    SRC_X,
    alu_sub:  1'b0,
    alu_dst:  DST_NONE,
    mul_en:   1'b0,
    mul_a:    SRC_X,
    mul_b:    SRC_X,
    mul_dt:   1'b0,
    rnd_dst:  DST_NONE
  };

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              out_free;
  logic              take;

  // At most one ALU operation, one multiply issue and one rounded product writeback per step.
  // A product issued in one step is rounded and written back in the next.
  function automatic cmd_t uop(logic [STEP_W-1:0] s);
    cmd_t c;
    c = CMD_IDLE;
    unique case (s)
      4'd0: begin
        c.alu_dst = DST_T0; c.alu_a = SRC_Y; c.alu_b = SRC_X; c.alu_sub = 1'b1;
        c.mul_en = 1'b1; c.mul_a = SRC_X; c.mul_b = SRC_Y;
      end
      4'd1: begin
        c.alu_dst = DST_T1; c.alu_a = SRC_RHO; c.alu_b = SRC_Z; c.alu_sub = 1'b1;
        c.mul_en = 1'b1; c.mul_a = SRC_BETA; c.mul_b = SRC_Z;
        c.rnd_dst = DST_T2;
      end
      4'd2: begin
        c.mul_en = 1'b1; c.mul_a = SRC_SIGMA; c.mul_b = SRC_T0;
        c.rnd_dst = DST_T3;
      end
      4'd3: begin
        c.alu_dst = DST_T2; c.alu_a = SRC_T2; c.alu_b = SRC_T3; c.alu_sub = 1'b1;
        c.mul_en = 1'b1; c.mul_a = SRC_X; c.mul_b = SRC_T1;
        c.rnd_dst = DST_T0;
      end
      4'd4: begin
        c.mul_en = 1'b1; c.mul_a = SRC_DT; c.mul_b = SRC_T0; c.mul_dt = 1'b1;
        c.rnd_dst = DST_T1;
      end
      4'd5: begin
        c.alu_dst = DST_T1; c.alu_a = SRC_T1; c.alu_b = SRC_Y; c.alu_sub = 1'b1;
        c.mul_en = 1'b1; c.mul_a = SRC_DT; c.mul_b = SRC_T2; c.mul_dt = 1'b1;
        c.rnd_dst = DST_T0;
      end
      4'd6: begin
        c.alu_dst = DST_NX; c.alu_a = SRC_X; c.alu_b = SRC_T0;
        c.mul_en = 1'b1; c.mul_a = SRC_DT; c.mul_b = SRC_T1; c.mul_dt = 1'b1;
        c.rnd_dst = DST_T2;
      end
      4'd7: begin
        c.alu_dst = DST_NZ; c.alu_a = SRC_Z; c.alu_b = SRC_T2;
        c.mul_en = 1'b1; c.mul_a = SRC_NX; c.mul_b = SRC_ZOOM;
        c.rnd_dst = DST_T1;
      end
      4'd8: begin
        c.alu_dst = DST_T0; c.alu_a = SRC_NZ; c.alu_b = SRC_ZOFF; c.alu_sub = 1'b1;
        c.rnd_dst = DST_RX;
      end
      4'd9: begin
        c.alu_dst = DST_NY; c.alu_a = SRC_Y; c.alu_b = SRC_T1;
        c.mul_en = 1'b1; c.mul_a = SRC_T0; c.mul_b = SRC_ZOOM;
      end
      4'd10: begin
        c.mul_en = 1'b1; c.mul_a = SRC_NY; c.mul_b = SRC_ZOOM;
        c.rnd_dst = DST_RZ;
      end
      4'd11: begin
        c.rnd_dst = DST_RY;
      end
      default: c = CMD_IDLE;
    endcase
    return c;
  endfunction

  assign out_free   = !point_valid || !point_stall;
  assign step_stall = !((state == ST_IDLE) || ((state == ST_HAND) && out_free));
  assign take       = step_valid && !step_stall;

  always_comb begin
    cmd          = (state == ST_RUN) ? uop(step) : CMD_IDLE;
    cmd.start    = take;
    cmd.commit   = (state == ST_RUN) && (step == LAST_STEP);
    cmd.out_load = (state == ST_HAND) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      point_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        point_valid <= 1'b1;
      end else if (!point_stall) begin
        point_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          if (step == LAST_STEP) begin
            state <= ST_HAND;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_HAND: begin
          if (out_free) begin
            if (take) begin
              state <= ST_RUN;
              step  <= '0;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_take_starts_run: assert property (@(posedge clk) disable iff (rst)
    (step_valid && !step_stall) |=> (state == ST_RUN && step == '0))
    else $error("accepted transaction did not start the step sequence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(point_valid && point_stall))
    else $error("result register loaded while a stalled transaction is held");

  a_run_ends_in_hand: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && step == LAST_STEP) |=> (state == ST_HAND))
    else $error("step sequence did not hand over its result");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> step_stall)
    else $error("input not stalled while a step is in progress");

endmodule

/* rtl/core/laes_dpath.sv */
`timescale 1ns / 1ps

module laes_dpath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  laes_pkg::cmd_t     cmd,
  input  laes_pkg::cfg_t     cfg,
  input  logic               restart,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic               last_of_run
);
  import laes_pkg::*;

  localparam int DT_BITS = 24;
  localparam logic signed [63:0] HALF_Q  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] HALF_DT = 64'sd1 <<< (DT_BITS - 1);
  localparam logic signed [31:0] START_RST = start_x_reset(FRAC_BITS);

  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [19:0]        step_count;
  logic signed [31:0] t0, t1, t2, t3;
  logic signed [31:0] nx, ny, nz;
  logic signed [31:0] res_x, res_y, res_z;
  logic               res_last;
  logic signed [63:0] prod;
  logic               prod_dt;

  logic signed [31:0] alu_a, alu_b, alu_res, mul_a, mul_b, rnd_res;
  logic signed [32:0] alu_sum;
  logic signed [63:0] mul_p, rnd_sum, rnd_shr;
  logic [19:0]        len;
  logic               last_hit;

  function automatic logic signed [31:0] sat33(logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat64(logic signed [63:0] v);
    if ((&v[63:31]) || !(|v[63:31])) begin
      return v[31:0];
    end
    return v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [31:0] pick(src_t s);
    logic signed [31:0] v;
    v = pos_x;
    unique case (s)
      SRC_X:     v = pos_x;
      SRC_Y:     v = pos_y;
      SRC_Z:     v = pos_z;
      SRC_NX:    v = nx;
      SRC_NY:    v = ny;
      SRC_NZ:    v = nz;
      SRC_T0:    v = t0;
      SRC_T1:    v = t1;
      SRC_T2:    v = t2;
      SRC_T3:    v = t3;
      SRC_SIGMA: v = {1'b0, cfg.sigma};
      SRC_RHO:   v = {1'b0, cfg.rho};
      SRC_BETA:  v = {1'b0, cfg.beta};
      SRC_DT:    v = {8'd0, cfg.time_step};
      SRC_ZOOM:  v = {1'b0, cfg.zoom};
      SRC_ZOFF:  v = cfg.z_offset;
    endcase
    return v;
  endfunction

  always_comb begin
    alu_a = pick(cmd.alu_a);
    alu_b = pick(cmd.alu_b);
    mul_a = pick(cmd.mul_a);
    mul_b = pick(cmd.mul_b);
  end

  assign alu_sum = cmd.alu_sub ? ({alu_a[31], alu_a} - {alu_b[31], alu_b})
                               : ({alu_a[31], alu_a} + {alu_b[31], alu_b});
  assign alu_res = sat33(alu_sum);

  assign mul_p = mul_a * mul_b;

  // Round to nearest with ties toward plus infinity: add half, then floor shift.
  assign rnd_sum = prod + (prod_dt ? HALF_DT : HALF_Q);
  assign rnd_shr = prod_dt ? (rnd_sum >>> DT_BITS) : (rnd_sum >>> FRAC_BITS);
  assign rnd_res = sat64(rnd_shr);

  // A zero run length behaves as one point per run.
  assign len      = (cfg.run_length == '0) ? 20'd1 : cfg.run_length;
  assign last_hit = ({1'b0, step_count} + 21'd1) >= {1'b0, len};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod    <= mul_p;
      prod_dt <= cmd.mul_dt;
    end

    if (cmd.alu_dst == DST_T0) t0 <= alu_res; else if (cmd.rnd_dst == DST_T0) t0 <= rnd_res;
    if (cmd.alu_dst == DST_T1) t1 <= alu_res; else if (cmd.rnd_dst == DST_T1) t1 <= rnd_res;
    if (cmd.alu_dst == DST_T2) t2 <= alu_res; else if (cmd.rnd_dst == DST_T2) t2 <= rnd_res;
    if (cmd.alu_dst == DST_T3) t3 <= alu_res; else if (cmd.rnd_dst == DST_T3) t3 <= rnd_res;
    if (cmd.alu_dst == DST_NX) nx <= alu_res; else if (cmd.rnd_dst == DST_NX) nx <= rnd_res;
    if (cmd.alu_dst == DST_NY) ny <= alu_res; else if (cmd.rnd_dst == DST_NY) ny <= rnd_res;
    if (cmd.alu_dst == DST_NZ) nz <= alu_res; else if (cmd.rnd_dst == DST_NZ) nz <= rnd_res;
    if (cmd.rnd_dst == DST_RX) res_x <= rnd_res;
    if (cmd.rnd_dst == DST_RY) res_y <= rnd_res;
    if (cmd.rnd_dst == DST_RZ) res_z <= rnd_res;

    if (cmd.commit) begin
      res_last <= last_hit;
    end

    if (cmd.out_load) begin
      point_x     <= res_x;
      point_y     <= res_y;
      point_z     <= res_z;
      last_of_run <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= START_RST;
      pos_y      <= '0;
      pos_z      <= '0;
      step_count <= '0;
    end else if (cmd.start && restart) begin
      pos_x      <= cfg.start_x;
      pos_y      <= '0;
      pos_z      <= '0;
      step_count <= '0;
    end else if (cmd.commit) begin
      if (last_hit) begin
        pos_x      <= cfg.start_x;
        pos_y      <= '0;
        pos_z      <= '0;
        step_count <= '0;
      end else begin
        pos_x      <= nx;
        pos_y      <= ny;
        pos_z      <= nz;
        step_count <= step_count + 20'd1;
      end
    end
  end

  a_no_dual_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.alu_dst != DST_NONE && cmd.alu_dst == cmd.rnd_dst))
    else $error("ALU and rounding unit write the same register");

  a_round_after_mul: assert property (@(posedge clk) disable iff (rst)
    (cmd.rnd_dst != DST_NONE) |-> $past(cmd.mul_en))
    else $error("rounded writeback without a product issued the step before");

  a_start_not_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.start && cmd.commit))
    else $error("new transaction accepted while the state is committed");

endmodule
